// ----- hw/rtl/sar_pkg.sv -----
// sar_pkg: shared types and codes for the sighting aggregate report block.
// No dependencies.
package sar_pkg;
  localparam logic [1:0] OP_RECEIVE  = 2'd0;
  localparam logic [1:0] OP_TICK     = 2'd1;
  localparam logic [1:0] OP_TRANSMIT = 2'd2;

  localparam logic [1:0] KIND_ENTRY = 2'd0;
  localparam logic [1:0] KIND_SLOW  = 2'd1;
  localparam logic [1:0] KIND_FAST  = 2'd2;

  localparam logic CFG_STATUS_RATIO = 1'b0;
  localparam logic CFG_SLOW_RATIO   = 1'b1;

  localparam int SUM_W  = 24;
  localparam int HITS_W = 16;

  // one slot word as kept in the slot memory
  typedef struct packed {
    logic [31:0]        uid;
    logic signed [7:0]  tx;
    logic signed [23:0] sum;
    logic [15:0]        hits;
  } slot_t;

  // divider request
  typedef struct packed {
    logic               go;
    logic signed [23:0] num;
    logic [15:0]        den;
  } div_req_t;
endpackage

// ----- hw/rtl/sar_div.sv -----
// sar_div: serial signed divide of a 24-bit sum by a 16-bit count, truncated.
// Uses sar_pkg. One quotient bit per cycle.
module sar_div (
  input  logic              clk,
  input  logic              rst_n,
  input  sar_pkg::div_req_t req,
  output logic              done,
  output logic signed [7:0] quot
);
  import sar_pkg::*;

  logic [23:0] rem_r, rem_nxt;
  logic [23:0] q_r, q_nxt;
  logic [23:0] mag_r, mag_nxt;
  logic [15:0] den_r;
  logic        neg_r;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, done_r;
  logic [24:0] trial;
  logic [23:0] qfin;

  always_comb begin
    trial = {rem_r, mag_r[23]} - {9'd0, den_r};
    rem_nxt = {rem_r[22:0], mag_r[23]};
    q_nxt = {q_r[22:0], 1'b0};
    if (!trial[24]) begin
      rem_nxt = trial[23:0];
      q_nxt[0] = 1'b1;
    end
    mag_nxt = {mag_r[22:0], 1'b0};
    cnt_nxt = cnt_r - 5'd1;
  end

  assign qfin = neg_r ? (~q_r + 24'd1) : q_r;
  assign quot = qfin[7:0];
  assign done = done_r;

  // iterate restoring division on magnitude
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd24;
        neg_r  <= req.num[23];
        mag_r  <= req.num[23] ? (~req.num + 24'd1) : req.num;
        den_r  <= req.den;
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        mag_r <= mag_nxt;
        cnt_r <= cnt_nxt;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- hw/rtl/sighting_aggregate_report.sv -----
// sighting_aggregate_report: slot table of radio sightings with reports.
// Uses sar_pkg and sar_div. Slot words live in one synchronous memory, valid
// bits in registers. Busy after accept: receive reads and compares each slot
// searched (at most SLOTS); tick and status transmit stay idle, a status word
// follows next cycle; a report does read, load, 24-step divide, done per used
// slot. Words cannot be stalled. Sync reset clears counters and valid bits.
module sighting_aggregate_report #(
  parameter int SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_opcode,
  input  logic [31:0]       in_seen_uid,
  input  logic signed [7:0] in_seen_tx_power,
  input  logic signed [7:0] in_seen_rx_power,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [15:0]       cfg_wdata,
  output logic              out_valid,
  output logic [1:0]        out_kind,
  output logic [31:0]       out_entry_uid,
  output logic signed [7:0] out_entry_tx_power,
  output logic signed [7:0] out_entry_rx_average,
  output logic [31:0]       out_epoch_seconds,
  output logic [15:0]       out_packet_number,
  output logic              out_last
);
  import sar_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_CMP  = 6'b000100,
    S_TRD  = 6'b001000,
    S_TDIV = 6'b010000,
    S_TWAIT = 6'b100000
  } state_t;

  state_t state_r;
  slot_t  mem [SLOTS];
  slot_t  rd_r;
  logic [SLOTS-1:0] valid_r;
  logic [IW-1:0] idx_r;
  logic [CW-1:0] used_r;
  logic [15:0] st_ratio_r, sl_ratio_r, tss_r, phase_r, pkt_r;
  logic [31:0] sec_r;
  logic [31:0] uid_r;
  logic signed [7:0] tx_r, rx_r;
  logic rd_valid_r;
  logic [15:0] tss_inc, phase_inc;
  logic [15:0] pkt_nxt;
  logic signed [24:0] sum_ext;
  logic signed [23:0] sum_sat;
  div_req_t dreq;
  logic ddone;
  logic signed [7:0] dq;
  logic is_last;

  sar_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(dq));

  assign busy = (state_r != S_IDLE);
  assign tss_inc = (tss_r != 16'hFFFF) ? tss_r + 16'd1 : tss_r;
  assign phase_inc = phase_r + 16'd1;
  assign pkt_nxt = pkt_r + 16'd1;
  assign sum_ext = 25'(rd_r.sum) + 25'(rx_r);
  assign sum_sat = (sum_ext > 25'sd8388607) ? 24'sh7FFFFF :
                   (sum_ext < -25'sd8388608) ? 24'sh800000 : sum_ext[23:0];
  assign is_last = (CW'(idx_r) + CW'(1)) == used_r;

  always_comb begin
    dreq.go  = (state_r == S_TDIV);
    dreq.num = rd_r.sum;
    dreq.den = rd_r.hits;
  end

  // slot memory: read into rd_r, written on a new entry or an update
  always_ff @(posedge clk) begin
    rd_r <= mem[idx_r];
    if (state_r == S_CMP && rd_valid_r) begin
      if (!valid_r[idx_r])
        mem[idx_r] <= '{uid: uid_r, tx: tx_r, sum: 24'(rx_r), hits: 16'd1};
      else if (rd_r.uid == uid_r && rd_r.tx == tx_r && rd_r.hits != 16'hFFFF)
        mem[idx_r] <= '{uid: rd_r.uid, tx: rd_r.tx, sum: sum_sat,
                        hits: rd_r.hits + 16'd1};
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      used_r <= '0;
      st_ratio_r <= 16'd4;
      sl_ratio_r <= 16'd16;
      tss_r <= '0;
      phase_r <= '0;
      sec_r <= '0;
      pkt_r <= '0;
      out_valid <= 1'b0;
      idx_r <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      rd_valid_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_STATUS_RATIO) st_ratio_r <= cfg_wdata;
        else sl_ratio_r <= cfg_wdata;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            uid_r <= in_seen_uid;
            tx_r <= in_seen_tx_power;
            rx_r <= in_seen_rx_power;
            idx_r <= '0;
            case (in_opcode)
              OP_RECEIVE: if (in_seen_uid != 32'd0) begin
                state_r <= S_RD;
              end
              OP_TICK: sec_r <= sec_r + 32'd1;
              OP_TRANSMIT: begin
                pkt_r <= pkt_nxt;
                if (used_r == '0 || tss_inc >= st_ratio_r) begin
                  tss_r <= '0;
                  out_valid <= 1'b1;
                  out_kind <= (phase_r == 16'd0) ? KIND_SLOW : KIND_FAST;
                  out_entry_uid <= '0;
                  out_entry_tx_power <= '0;
                  out_entry_rx_average <= '0;
                  out_epoch_seconds <= (phase_r == 16'd0) ? 32'd0 : sec_r;
                  out_packet_number <= pkt_nxt;
                  out_last <= 1'b1;
                  phase_r <= (phase_inc >= sl_ratio_r) ? 16'd0 : phase_inc;
                end else begin
                  tss_r <= tss_inc;
                  state_r <= S_TRD;
                end
              end
              default: ;
            endcase
          end
        end
        S_RD: begin
          rd_valid_r <= 1'b1;
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (!valid_r[idx_r]) begin
            valid_r[idx_r] <= 1'b1;
            used_r <= used_r + CW'(1);
            state_r <= S_IDLE;
          end else if (rd_r.uid == uid_r && rd_r.tx == tx_r) begin
            state_r <= S_IDLE;
          end else if (32'(idx_r) == SLOTS - 1) begin
            state_r <= S_IDLE;
          end else begin
            idx_r <= idx_r + IW'(1);
            state_r <= S_RD;
          end
        end
        S_TRD: state_r <= S_TDIV;
        S_TDIV: state_r <= S_TWAIT;
        S_TWAIT: begin
          if (ddone) begin
            out_valid <= 1'b1;
            out_kind <= KIND_ENTRY;
            out_entry_uid <= rd_r.uid;
            out_entry_tx_power <= rd_r.tx;
            out_entry_rx_average <= dq;
            out_epoch_seconds <= '0;
            out_packet_number <= pkt_r;
            out_last <= is_last;
            if (is_last) begin
              valid_r <= '0;
              used_r <= '0;
              state_r <= S_IDLE;
            end else begin
              idx_r <= idx_r + IW'(1);
              state_r <= S_TRD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
